// ===== hdl/bpad_pkg.sv =====
// shared types and constants for the bolus peak and arrival detector
package bpad_pkg;

  localparam int SIG_BITS        = 24;
  localparam int THR_BITS        = 25;
  localparam int IDX_OUT_BITS    = 8;
  localparam int MAX_FRAMES_DEF  = 256;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic [SIG_BITS-1:0] mean_signal;
    logic                last_frame;
  } item_t;

  typedef struct packed {
    logic [IDX_OUT_BITS-1:0] peak_index;
    logic [SIG_BITS-1:0]     peak_value;
    logic                    arrival_found;
    logic [IDX_OUT_BITS-1:0] arrival_index;
    logic [SIG_BITS-1:0]     arrival_value;
    logic [SIG_BITS-1:0]     uptake_slope;
    logic                    too_many_frames;
  } result_t;

  typedef struct packed {
    logic [IDX_OUT_BITS-1:0] peak_index;
    logic [SIG_BITS-1:0]     peak_value;
    logic                    arrival_found;
    logic [IDX_OUT_BITS-1:0] arrival_index;
    logic [SIG_BITS-1:0]     arrival_value;
    logic                    too_many_frames;
    logic [SIG_BITS-1:0]     dividend;
  } job_t;

endpackage

// ===== hdl/bpad_front.sv =====
// frame tracker: peak and arrival search, emits one job per sequence
module bpad_front #(
  parameter int MAX_FRAMES = bpad_pkg::MAX_FRAMES_DEF,
  parameter int IDX_W      = $clog2(MAX_FRAMES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bpad_pkg::item_t               in_data,
  input  logic signed [bpad_pkg::THR_BITS-1:0] threshold,
  input  logic                          q_full,
  output logic                          q_push,
  output bpad_pkg::job_t                q_job,
  output logic [IDX_W-1:0]              q_divisor
);
  import bpad_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  logic [SIG_BITS-1:0] prev_r, prev_nxt, upd_prev;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, upd_cnt;
  logic [SIG_BITS-1:0] best_sig_r, best_sig_nxt, upd_best_sig;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt, upd_best_idx;
  logic                cross_r, cross_nxt, upd_cross;
  logic [IDX_W-1:0]    cross_idx_r, cross_idx_nxt, upd_cross_idx;
  logic [SIG_BITS-1:0] cross_sig_r, cross_sig_nxt, upd_cross_sig;
  logic                ovf_r, ovf_nxt, upd_ovf;

  logic                accept;
  logic                full;
  logic [IDX_W-1:0]    idx;
  logic signed [SIG_BITS+1:0] rise;
  logic signed [SIG_BITS+1:0] thr_ext;
  logic                found;
  logic [IDX_W+IDX_OUT_BITS-1:0] peak_ext, arr_ext;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(MAX_FRAMES));
  assign idx      = cnt_r[IDX_W-1:0];
  assign rise     = $signed({2'b00, in_data.mean_signal}) - $signed({2'b00, prev_r});
  assign thr_ext  = {threshold[THR_BITS-1], threshold};

  always_comb begin
    upd_prev      = prev_r;
    upd_cnt       = cnt_r;
    upd_best_sig  = best_sig_r;
    upd_best_idx  = best_idx_r;
    upd_cross     = cross_r;
    upd_cross_idx = cross_idx_r;
    upd_cross_sig = cross_sig_r;
    upd_ovf       = ovf_r;
    if (full) begin
      upd_ovf = 1'b1;
    end else begin
      if ((cnt_r != '0) && !cross_r && (rise > thr_ext)) begin
        upd_cross     = 1'b1;
        upd_cross_idx = idx - IDX_W'(1);
        upd_cross_sig = prev_r;
      end
      if ((cnt_r == '0) || (in_data.mean_signal > best_sig_r)) begin
        upd_best_sig = in_data.mean_signal;
        upd_best_idx = idx;
      end
      upd_prev = in_data.mean_signal;
      upd_cnt  = cnt_r + CNT_W'(1);
    end
  end

  assign found    = upd_cross && (upd_cross_idx < upd_best_idx);
  assign peak_ext = {{IDX_OUT_BITS{1'b0}}, upd_best_idx};
  assign arr_ext  = {{IDX_OUT_BITS{1'b0}}, upd_cross_idx};

  always_comb begin
    q_push                = accept && in_data.last_frame;
    q_job.peak_index      = peak_ext[IDX_OUT_BITS-1:0];
    q_job.peak_value      = upd_best_sig;
    q_job.arrival_found   = found;
    q_job.arrival_index   = found ? arr_ext[IDX_OUT_BITS-1:0] : '0;
    q_job.arrival_value   = found ? upd_cross_sig : '0;
    q_job.too_many_frames = upd_ovf;
    q_job.dividend        = found ? (upd_best_sig - upd_cross_sig) : '0;
    q_divisor             = found ? (upd_best_idx - upd_cross_idx) : IDX_W'(1);
  end

  always_comb begin
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    best_sig_nxt  = best_sig_r;
    best_idx_nxt  = best_idx_r;
    cross_nxt     = cross_r;
    cross_idx_nxt = cross_idx_r;
    cross_sig_nxt = cross_sig_r;
    ovf_nxt       = ovf_r;
    if (accept && in_data.last_frame) begin
      prev_nxt      = '0;
      cnt_nxt       = '0;
      best_sig_nxt  = '0;
      best_idx_nxt  = '0;
      cross_nxt     = 1'b0;
      cross_idx_nxt = '0;
      cross_sig_nxt = '0;
      ovf_nxt       = 1'b0;
    end else if (accept) begin
      prev_nxt      = upd_prev;
      cnt_nxt       = upd_cnt;
      best_sig_nxt  = upd_best_sig;
      best_idx_nxt  = upd_best_idx;
      cross_nxt     = upd_cross;
      cross_idx_nxt = upd_cross_idx;
      cross_sig_nxt = upd_cross_sig;
      ovf_nxt       = upd_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      cnt_r       <= '0;
      best_sig_r  <= '0;
      best_idx_r  <= '0;
      cross_r     <= 1'b0;
      cross_idx_r <= '0;
      cross_sig_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      best_sig_r  <= best_sig_nxt;
      best_idx_r  <= best_idx_nxt;
      cross_r     <= cross_nxt;
      cross_idx_r <= cross_idx_nxt;
      cross_sig_r <= cross_sig_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/bpad_queue.sv =====
// short job queue between tracker and divider
module bpad_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import bpad_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/bpad_back.sv =====
// slope divider and output register
module bpad_back #(
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  bpad_pkg::job_t     q_job,
  input  logic [IDX_W-1:0]   q_divisor,
  output logic               out_valid,
  input  logic               out_stall,
  output bpad_pkg::result_t  out_data
);
  import bpad_pkg::*;

  localparam int STEP_W = $clog2(SIG_BITS + 1);

  logic                busy_r, busy_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  job_t                job_r, job_nxt;
  logic [IDX_W-1:0]    div_r, div_nxt;
  logic [IDX_W-1:0]    rem_r, rem_nxt;
  logic [SIG_BITS-1:0] quo_r, quo_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  logic [IDX_W:0]      trial;
  logic [IDX_W:0]      trial_sub;
  logic                out_free;

  assign trial     = {rem_r, quo_r[SIG_BITS-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = !busy_r && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    job_nxt       = job_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SIG_BITS);
      job_nxt  = q_job;
      div_nxt  = q_divisor;
      rem_nxt  = '0;
      quo_nxt  = q_job.dividend;
    end else if (busy_r && (step_r != '0)) begin
      step_nxt = step_r - STEP_W'(1);
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial_sub[IDX_W-1:0];
        quo_nxt = {quo_r[SIG_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[IDX_W-1:0];
        quo_nxt = {quo_r[SIG_BITS-2:0], 1'b0};
      end
    end else if (busy_r && out_free) begin
      busy_nxt                = 1'b0;
      out_valid_nxt           = 1'b1;
      out_nxt.peak_index      = job_r.peak_index;
      out_nxt.peak_value      = job_r.peak_value;
      out_nxt.arrival_found   = job_r.arrival_found;
      out_nxt.arrival_index   = job_r.arrival_index;
      out_nxt.arrival_value   = job_r.arrival_value;
      out_nxt.uptake_slope    = job_r.arrival_found ? quo_r : '0;
      out_nxt.too_many_frames = job_r.too_many_frames;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/bolus_peak_arrival_detector_core.sv =====
// top level: frame tracker, job queue and slope divider
// throughput: one frame word per cycle while in_stall is low (it is high while
//   the job queue is full); one result per sequence; the bit-serial slope divider
//   takes a new job from the queue only after it has finished the last one
// reset: synchronous active-low rst_n clears sequence state, queue and
//   threshold (to 0); no clearing pass
module bolus_peak_arrival_detector_core #(
  parameter int MAX_FRAMES = bpad_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bpad_pkg::item_t               in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bpad_pkg::result_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpad_pkg::THR_BITS-1:0] cfg_data
);
  import bpad_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int QW    = $bits(job_t) + IDX_W;

  logic signed [THR_BITS-1:0] thr_r, thr_nxt;
  logic                       q_full, q_push, q_pop, q_empty;
  job_t                       push_job, pop_job;
  logic [IDX_W-1:0]           push_div, pop_div;
  logic [QW-1:0]              q_rdata;

  assign cfg_ready = 1'b1;
  assign thr_nxt   = (cfg_valid && cfg_ready) ? $signed(cfg_data) : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  bpad_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .threshold (thr_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_divisor (push_div)
  );

  bpad_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({push_job, push_div}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign pop_job = q_rdata[QW-1:IDX_W];
  assign pop_div = q_rdata[IDX_W-1:0];

  bpad_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_job     (pop_job),
    .q_divisor (pop_div),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/bolus_result_checker.sv =====
// checker for the bolus detector: tracks threshold and frame words, predicts and compares results
`timescale 1ns / 1ps

module bolus_result_checker
  import bpad_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  item_t               in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  result_t             out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [THR_BITS-1:0] cfg_data,
  output int                  mismatch_count,
  output int                  results_due
);

  localparam int SHOWN_MAX = 40;

  logic [THR_BITS-1:0]     threshold_q;
  logic [SIG_BITS-1:0]     prev_sig;
  logic [SIG_BITS-1:0]     peak_sig;
  logic [SIG_BITS-1:0]     cross_sig;
  logic [IDX_OUT_BITS-1:0] peak_idx;
  logic [IDX_OUT_BITS-1:0] cross_idx;
  logic                    cross_seen;
  logic                    overflow_seen;
  int                      frames_kept;
  int                      errs;
  result_t                 summaries_due[$];

  task automatic report_mismatch(input string msg);
    errs++;
    if (errs <= SHOWN_MAX) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_sequence();
    prev_sig      = '0;
    peak_sig      = '0;
    cross_sig     = '0;
    peak_idx      = '0;
    cross_idx     = '0;
    cross_seen    = 1'b0;
    overflow_seen = 1'b0;
    frames_kept   = 0;
  endtask

  task automatic take_frame(input item_t w);
    longint  rise;
    int      span;
    result_t r;
    if (frames_kept >= MAX_FRAMES_DEF) begin
      overflow_seen = 1'b1;
    end else begin
      if (frames_kept > 0 && !cross_seen) begin
        rise = longint'(w.mean_signal) - longint'(prev_sig);
        if (rise > longint'($signed(threshold_q))) begin
          cross_seen = 1'b1;
          cross_idx  = IDX_OUT_BITS'(frames_kept - 1);
          cross_sig  = prev_sig;
        end
      end
      if (frames_kept == 0 || w.mean_signal > peak_sig) begin
        peak_sig = w.mean_signal;
        peak_idx = IDX_OUT_BITS'(frames_kept);
      end
      prev_sig = w.mean_signal;
      frames_kept++;
    end
    if (w.last_frame) begin
      r = '0;
      r.peak_index      = peak_idx;
      r.peak_value      = peak_sig;
      r.too_many_frames = overflow_seen;
      if (cross_seen && cross_idx < peak_idx) begin
        span = int'(peak_idx) - int'(cross_idx);
        r.arrival_found = 1'b1;
        r.arrival_index = cross_idx;
        r.arrival_value = cross_sig;
        r.uptake_slope  = SIG_BITS'((int'(peak_sig) - int'(cross_sig)) / span);
      end
      summaries_due.insert(summaries_due.size(), r);
      clear_sequence();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      threshold_q = '0;
      clear_sequence();
      summaries_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        take_frame(in_data);
      end
      if (out_valid && !out_stall) begin
        if (summaries_due.size() == 0) begin
          report_mismatch($sformatf("result word with none due: 0x%0h", out_data));
        end else begin
          want = summaries_due.pop_front();
          compare_field("peak_index", out_data.peak_index, want.peak_index);
          compare_field("peak_value", out_data.peak_value, want.peak_value);
          compare_field("arrival_found", out_data.arrival_found, want.arrival_found);
          compare_field("arrival_index", out_data.arrival_index, want.arrival_index);
          compare_field("arrival_value", out_data.arrival_value, want.arrival_value);
          compare_field("uptake_slope", out_data.uptake_slope, want.uptake_slope);
          compare_field("too_many_frames", out_data.too_many_frames,
                        want.too_many_frames);
        end
      end
    end
    mismatch_count <= errs;
    results_due    <= summaries_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the bolus detector testbench: clock, reset, frame and threshold stimulus, verdict
`timescale 1ns / 1ps

module testbench;
  import bpad_pkg::*;

  localparam int SETTLE_CYCLES = SIG_BITS + 16;
  localparam int PHASE_ITEMS   = 215;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  item_t               in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  result_t             out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THR_BITS-1:0] cfg_data  = '0;
  int                  mismatch_count;
  int                  results_due;
  int                  burst_left = 0;
  int                  items_sent = 0;
  int                  stall_left = 0;

  bolus_peak_arrival_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bolus_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #5 clk = ~clk;

  // receiver: long stalls, free stretches and single-cycle chatter
  always @(posedge clk) begin
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 40);
      end else if (pick == 1) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(20, 150);
      end else begin
        out_stall  <= 1'($urandom_range(0, 1));
        stall_left = 1;
      end
    end
    stall_left--;
  end

  task automatic send_word(input item_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic frame(input logic [SIG_BITS-1:0] sig, input logic last);
    item_t w;
    w.mean_signal = sig;
    w.last_frame  = last;
    send_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_BITS-1:0] thr);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // bolus curves with noise, flat levels and pure noise
  task automatic send_sequence(input int len);
    int                  shape;
    int                  top_at;
    int                  floor_lvl;
    int                  i;
    longint              height;
    longint              v;
    logic [SIG_BITS-1:0] level;
    item_t               w;
    shape     = $urandom_range(0, 9);
    top_at    = $urandom_range(0, len - 1);
    floor_lvl = $urandom_range(0, 4095);
    height    = $urandom_range(0, 24'hFFFFFF - floor_lvl);
    case ($urandom_range(0, 2))
      0: level = '0;
      1: level = '1;
      default: level = SIG_BITS'($urandom());
    endcase
    for (i = 0; i < len; i++) begin
      if (shape < 6) begin
        if (i <= top_at) begin
          v = floor_lvl + ((top_at == 0) ? height : height * i / top_at);
        end else begin
          v = floor_lvl + height * (len - 1 - i) / (len - 1 - top_at);
        end
        v = v + longint'($urandom_range(0, 511)) - 256;
        if (v < 0) begin
          v = 0;
        end else if (v > 24'hFFFFFF) begin
          v = 24'hFFFFFF;
        end
      end else if (shape == 6) begin
        v = level;
      end else begin
        v = $urandom() & 24'hFFFFFF;
      end
      w.mean_signal = v[SIG_BITS-1:0];
      w.last_frame  = (i == len - 1);
      send_word(w);
    end
  endtask

  initial begin
    logic [THR_BITS-1:0] phase_thr[6];
    int                  ph;
    int                  seq_no;
    int                  len;
    int                  budget;

    phase_thr[0] = {1'b1, {(THR_BITS-1){1'b0}}};
    phase_thr[1] = {1'b0, {(THR_BITS-1){1'b1}}};
    phase_thr[2] = THR_BITS'($urandom_range(1, 65535));
    phase_thr[3] = -THR_BITS'($urandom_range(1, 65535));
    phase_thr[4] = THR_BITS'($urandom());
    phase_thr[5] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single frames at both extremes
    frame(24'h000000, 1'b1);
    frame(24'hFFFFFF, 1'b1);
    // full-scale rise
    frame(24'h000000, 1'b0);
    frame(24'hFFFFFF, 1'b1);
    // equal maxima
    frame(24'd5, 1'b0);
    frame(24'd9, 1'b0);
    frame(24'd9, 1'b0);
    frame(24'd3, 1'b1);
    // first rise only after the peak
    frame(24'd100, 1'b0);
    frame(24'd50, 1'b0);
    frame(24'd40, 1'b0);
    frame(24'd60, 1'b1);
    // slope truncation
    frame(24'd0, 1'b0);
    frame(24'd3, 1'b0);
    frame(24'd7, 1'b1);
    // no rise at all
    frame(24'd0, 1'b0);
    frame(24'd0, 1'b0);
    frame(24'd0, 1'b1);
    // flat baseline then a late steep rise
    frame(24'd8, 1'b0);
    frame(24'd8, 1'b0);
    frame(24'hFFFFFE, 1'b0);
    frame(24'hFFFFFF, 1'b1);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      set_threshold(phase_thr[ph]);
      budget = items_sent + PHASE_ITEMS;
      seq_no = 0;
      while (items_sent < budget) begin
        if (seq_no == 0 && ph == 2) begin
          len = MAX_FRAMES_DEF + 2;
        end else if (seq_no == 0 && ph == 4) begin
          len = MAX_FRAMES_DEF;
        end else if ($urandom_range(0, 39) == 0) begin
          len = $urandom_range(MAX_FRAMES_DEF - 6, MAX_FRAMES_DEF + 6);
        end else begin
          len = $urandom_range(1, 14);
        end
        send_sequence(len);
        seq_no++;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bpad_pkg.sv
hdl/bpad_front.sv
hdl/bpad_queue.sv
hdl/bpad_back.sv
hdl/bolus_peak_arrival_detector_core.sv
tb/sv/bolus_result_checker.sv
tb/sv/testbench.sv
